FILE: hw/rtl/poi_pkg.sv
`timescale 1ns / 1ps
// poi_pkg: beat structs, fixed-point constants and the rounding helper
// used by the odometry integrator top level and its shared multiplier
package poi_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CORE_W = 32;

    localparam logic OP_VEL  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] vel_yaw;
        logic        [23:0] delta_time;
    } poi_cmd_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [23:0] held_vel_x;
        logic signed [23:0] held_vel_y;
        logic signed [23:0] held_vel_yaw;
    } poi_pose_t;

    // multiplier-side constants
    localparam logic signed [MUL_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [MUL_W-1:0] RAD_TO_BANG = 33'sd2670177;

    // taylor coefficients in q2.30
    localparam logic signed [CORE_W-1:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [CORE_W-1:0] C_I3    = 32'sd178956971;
    localparam logic signed [CORE_W-1:0] C_I5    = 32'sd8947849;
    localparam logic signed [CORE_W-1:0] C_I7    = 32'sd213044;
    localparam logic signed [CORE_W-1:0] C_I2    = 32'sd536870912;
    localparam logic signed [CORE_W-1:0] C_I4    = 32'sd44739243;
    localparam logic signed [CORE_W-1:0] C_I6    = 32'sd1491308;
    localparam logic signed [CORE_W-1:0] C_I8    = 32'sd26631;

    // round half up then arithmetic shift right
    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] v,
        input logic        [5:0]        sh
    );
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) << (sh - 6'd1);
        return (v + half) >>> sh;
    endfunction

endpackage

FILE: hw/rtl/planar_odometry_integrator.sv
`timescale 1ns / 1ps
// planar_odometry_integrator: dead-reckoning pose integrator
// a velocity beat is taken while idle and gives no result
// a tick beat runs a sin/cos evaluation, a rotate and integrate pass and a second
// sin/cos evaluation, all through the one 33x33 multiplier, to a valid pose
// no beat enters mid-tick; the pose register lets the next beat in while a pose waits
// reset (rst_n low, asynchronous) clears position, heading and velocities to zero
module planar_odometry_integrator
    import poi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  poi_cmd_t  cmd,
    output logic      pose_valid,
    input  logic      pose_ready,
    output poi_pose_t pose
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SC1,
        ST_VEL,
        ST_SC2,
        ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        WB_NONE,
        WB_X,
        WB_X2,
        WB_S5,
        WB_S3,
        WB_S1,
        WB_SIN,
        WB_C6,
        WB_C4,
        WB_C2,
        WB_COS,
        WB_ACCA,
        WB_ACCB,
        WB_WX,
        WB_WY,
        WB_Q,
        WB_DANG,
        WB_PX,
        WB_PY
    } wb_t;

    localparam logic [3:0] SC_LAST  = 4'd13;
    localparam logic [3:0] VEL_LAST = 4'd8;

    state_t state_reg;
    logic [3:0] sub_reg;
    wb_t wb_reg;
    wb_t wb_issue;
    logic pose_valid_reg;
    poi_pose_t pose_reg;

    logic signed [31:0] x_pos_reg;
    logic signed [31:0] y_pos_reg;
    logic        [31:0] yaw_reg;
    logic signed [23:0] fwd_reg;
    logic signed [23:0] side_reg;
    logic signed [23:0] turn_reg;
    logic        [23:0] dt_reg;

    logic        [1:0]        k_reg;
    logic signed [CORE_W-1:0] x_reg;
    logic signed [CORE_W-1:0] x2_reg;
    logic signed [CORE_W-1:0] ts_reg;
    logic signed [CORE_W-1:0] tc_reg;
    logic signed [CORE_W-1:0] s_reg;
    logic signed [CORE_W-1:0] c_reg;
    logic signed [CORE_W-1:0] sn_reg;
    logic signed [CORE_W-1:0] cs_reg;
    logic signed [63:0]       acca_reg;
    logic signed [63:0]       accb_reg;
    logic signed [24:0]       wx_reg;
    logic signed [24:0]       wy_reg;
    logic signed [36:0]       q_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     k_load;
    logic                     fold_en;
    logic        [31:0]       sc_angle;

    logic signed [PROD_W-1:0] r30;
    logic signed [PROD_W-1:0] r20;
    logic signed [PROD_W-1:0] r12;
    logic signed [PROD_W-1:0] wx_round;
    logic signed [PROD_W-1:0] wy_round;
    logic signed [PROD_W-1:0] dang_round;
    logic signed [33:0]       px_sum;
    logic signed [33:0]       py_sum;

    logic cmd_accept;
    logic pose_load;

    function automatic logic signed [31:0] sat_pos(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return 32'(v);
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
        logic signed [32:0] r;
        r = (33'(v) + 33'sd16384) >>> 15;
        if (r > 33'sd32767)
            return 16'sh7FFF;
        else if (r < -33'sd32768)
            return 16'sh8000;
        else
            return 16'(r);
    endfunction

    poi_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign cmd_accept = cmd_valid && cmd_ready;
    assign pose_valid = pose_valid_reg;
    assign pose       = pose_reg;
    assign pose_load  = (state_reg == ST_EMIT) && (!pose_valid_reg || pose_ready);

    // second pass evaluates at half the new heading for the quaternion
    assign sc_angle = (state_reg == ST_SC2) ? {1'b0, yaw_reg[31:1]} : yaw_reg;

    // micro-op decode: operands for the multiplier and where the product lands
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        wb_issue = WB_NONE;
        k_load   = 1'b0;
        fold_en  = 1'b0;
        case (state_reg)
            ST_SC1, ST_SC2:
            begin
                case (sub_reg)
                    4'd0:
                    begin
                        // residual from the nearest quarter turn is the low 30 bits
                        mul_a    = MUL_W'($signed(sc_angle[29:0]));
                        mul_b    = HALF_PI_Q30;
                        wb_issue = WB_X;
                        k_load   = 1'b1;
                    end
                    4'd2:
                    begin
                        mul_a    = MUL_W'(x_reg);
                        mul_b    = MUL_W'(x_reg);
                        wb_issue = WB_X2;
                    end
                    4'd4:
                    begin
                        mul_a    = MUL_W'(x2_reg);
                        mul_b    = MUL_W'(C_I7);
                        wb_issue = WB_S5;
                    end
                    4'd5:
                    begin
                        mul_a    = MUL_W'(x2_reg);
                        mul_b    = MUL_W'(C_I8);
                        wb_issue = WB_C6;
                    end
                    4'd6:
                    begin
                        mul_a    = MUL_W'(x2_reg);
                        mul_b    = MUL_W'(ts_reg);
                        wb_issue = WB_S3;
                    end
                    4'd7:
                    begin
                        mul_a    = MUL_W'(x2_reg);
                        mul_b    = MUL_W'(tc_reg);
                        wb_issue = WB_C4;
                    end
                    4'd8:
                    begin
                        mul_a    = MUL_W'(x2_reg);
                        mul_b    = MUL_W'(ts_reg);
                        wb_issue = WB_S1;
                    end
                    4'd9:
                    begin
                        mul_a    = MUL_W'(x2_reg);
                        mul_b    = MUL_W'(tc_reg);
                        wb_issue = WB_C2;
                    end
                    4'd10:
                    begin
                        mul_a    = MUL_W'(x_reg);
                        mul_b    = MUL_W'(ts_reg);
                        wb_issue = WB_SIN;
                    end
                    4'd11:
                    begin
                        mul_a    = MUL_W'(x2_reg);
                        mul_b    = MUL_W'(tc_reg);
                        wb_issue = WB_COS;
                    end
                    4'd13:
                    begin
                        fold_en = 1'b1;
                    end
                    default:
                    begin
                        wb_issue = WB_NONE;
                    end
                endcase
            end
            ST_VEL:
            begin
                case (sub_reg)
                    4'd0:
                    begin
                        mul_a    = MUL_W'(fwd_reg);
                        mul_b    = MUL_W'(cs_reg);
                        wb_issue = WB_ACCA;
                    end
                    4'd1:
                    begin
                        mul_a    = MUL_W'(fwd_reg);
                        mul_b    = MUL_W'(sn_reg);
                        wb_issue = WB_ACCB;
                    end
                    4'd2:
                    begin
                        mul_a    = MUL_W'(turn_reg);
                        mul_b    = MUL_W'(dt_reg);
                        wb_issue = WB_Q;
                    end
                    4'd3:
                    begin
                        mul_a    = MUL_W'(side_reg);
                        mul_b    = MUL_W'(sn_reg);
                        wb_issue = WB_WX;
                    end
                    4'd4:
                    begin
                        mul_a    = MUL_W'(side_reg);
                        mul_b    = MUL_W'(cs_reg);
                        wb_issue = WB_WY;
                    end
                    4'd5:
                    begin
                        // heading scale split in two parts of q: low 24 bits and high 13 bits
                        mul_a    = MUL_W'(q_reg[23:0]);
                        mul_b    = RAD_TO_BANG;
                        wb_issue = WB_ACCA;
                    end
                    4'd6:
                    begin
                        mul_a    = MUL_W'($signed(q_reg[36:24]));
                        mul_b    = RAD_TO_BANG;
                        wb_issue = WB_DANG;
                    end
                    4'd7:
                    begin
                        mul_a    = MUL_W'(wx_reg);
                        mul_b    = MUL_W'(dt_reg);
                        wb_issue = WB_PX;
                    end
                    4'd8:
                    begin
                        mul_a    = MUL_W'(wy_reg);
                        mul_b    = MUL_W'(dt_reg);
                        wb_issue = WB_PY;
                    end
                    default:
                    begin
                        wb_issue = WB_NONE;
                    end
                endcase
            end
            default:
            begin
                wb_issue = WB_NONE;
            end
        endcase
    end

    // rounded forms of the registered product
    always_comb
    begin
        r30        = round_shift(prod, 6'd30);
        r20        = round_shift(prod, 6'd20);
        r12        = round_shift(prod, 6'd12);
        wx_round   = round_shift(PROD_W'(acca_reg) - prod, 6'd30);
        wy_round   = round_shift(PROD_W'(accb_reg) + prod, 6'd30);
        dang_round = round_shift(PROD_W'(acca_reg) + (prod <<< 24), 6'd16);
        px_sum     = 34'(x_pos_reg) + 34'(r20);
        py_sum     = 34'(y_pos_reg) + 34'(r20);
    end

    // sequencer, handshake, architectural state and pose beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sub_reg        <= '0;
            wb_reg         <= WB_NONE;
            pose_valid_reg <= 1'b0;
            pose_reg       <= '0;
            x_pos_reg      <= '0;
            y_pos_reg      <= '0;
            yaw_reg        <= '0;
            fwd_reg        <= '0;
            side_reg       <= '0;
            turn_reg       <= '0;
        end
        else
        begin
            wb_reg <= wb_issue;

            case (state_reg)
                ST_IDLE:
                begin
                    sub_reg <= '0;
                    if (cmd_accept)
                    begin
                        if (cmd.op == OP_VEL)
                        begin
                            fwd_reg  <= cmd.vel_x;
                            side_reg <= cmd.vel_y;
                            turn_reg <= cmd.vel_yaw;
                        end
                        else
                        begin
                            state_reg <= ST_SC1;
                        end
                    end
                end
                ST_SC1:
                begin
                    if (sub_reg == SC_LAST)
                    begin
                        sub_reg   <= '0;
                        state_reg <= ST_VEL;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 4'd1;
                    end
                end
                ST_VEL:
                begin
                    if (sub_reg == VEL_LAST)
                    begin
                        sub_reg   <= '0;
                        state_reg <= ST_SC2;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 4'd1;
                    end
                end
                ST_SC2:
                begin
                    if (sub_reg == SC_LAST)
                    begin
                        sub_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 4'd1;
                    end
                end
                ST_EMIT:
                begin
                    if (pose_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (pose_load)
                pose_valid_reg <= 1'b1;
            else if (pose_ready)
                pose_valid_reg <= 1'b0;

            if (pose_load)
            begin
                pose_reg.pos_x        <= x_pos_reg;
                pose_reg.pos_y        <= y_pos_reg;
                pose_reg.heading      <= yaw_reg;
                pose_reg.quat_z       <= to_q15(sn_reg);
                pose_reg.quat_w       <= to_q15(cs_reg);
                pose_reg.held_vel_x   <= fwd_reg;
                pose_reg.held_vel_y   <= side_reg;
                pose_reg.held_vel_yaw <= turn_reg;
            end

            case (wb_reg)
                WB_PX:   x_pos_reg <= sat_pos(px_sum);
                WB_PY:   y_pos_reg <= sat_pos(py_sum);
                WB_DANG: yaw_reg   <= yaw_reg + dang_round[31:0];
                default: ;
            endcase
        end
    end

    // datapath scratch registers
    always_ff @(posedge clk)
    begin
        if (cmd_accept && cmd.op == OP_TICK)
            dt_reg <= cmd.delta_time;

        if (k_load)
            k_reg <= sc_angle[31:30] + 2'(sc_angle[29]);

        if (fold_en)
        begin
            case (k_reg)
                2'd0:
                begin
                    sn_reg <= s_reg;
                    cs_reg <= c_reg;
                end
                2'd1:
                begin
                    sn_reg <= c_reg;
                    cs_reg <= -s_reg;
                end
                2'd2:
                begin
                    sn_reg <= -s_reg;
                    cs_reg <= -c_reg;
                end
                default:
                begin
                    sn_reg <= -c_reg;
                    cs_reg <= s_reg;
                end
            endcase
        end

        case (wb_reg)
            WB_X:    x_reg    <= CORE_W'(r30);
            WB_X2:   x2_reg   <= CORE_W'(r30);
            WB_S5:   ts_reg   <= C_I5 - CORE_W'(r30);
            WB_S3:   ts_reg   <= C_I3 - CORE_W'(r30);
            WB_S1:   ts_reg   <= ONE_Q30 - CORE_W'(r30);
            WB_SIN:  s_reg    <= CORE_W'(r30);
            WB_C6:   tc_reg   <= C_I6 - CORE_W'(r30);
            WB_C4:   tc_reg   <= C_I4 - CORE_W'(r30);
            WB_C2:   tc_reg   <= C_I2 - CORE_W'(r30);
            WB_COS:  c_reg    <= ONE_Q30 - CORE_W'(r30);
            WB_ACCA: acca_reg <= 64'(prod);
            WB_ACCB: accb_reg <= 64'(prod);
            WB_WX:   wx_reg   <= 25'(wx_round);
            WB_WY:   wy_reg   <= 25'(wy_round);
            WB_Q:    q_reg    <= 37'(r12);
            default: ;
        endcase
    end

    // a new pose only appears out of the emit state
    a_pose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose_valid) |-> $past(state_reg == ST_EMIT))
        else $error("pose beat raised outside emit");

    // a tick beat starts the sequencer and blocks further beats
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept && cmd.op == OP_TICK |=> state_reg == ST_SC1 && sub_reg == 4'd0 && !cmd_ready)
        else $error("tick beat did not start the sequencer");

    // a velocity beat gives no pose
    a_vel_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept && cmd.op == OP_VEL |=> state_reg == ST_IDLE && !$rose(pose_valid))
        else $error("velocity beat produced a pose");

    // no product writeback left over while the sequencer stays idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && $past(state_reg == ST_IDLE) |-> wb_reg == WB_NONE)
        else $error("writeback pending while idle");

endmodule

FILE: hw/rtl/poi_mul.sv
`timescale 1ns / 1ps
// poi_mul: shared signed multiplier with a registered product
// depends on poi_pkg for operand and product widths
module poi_mul
    import poi_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

FILE: sim/odometry_pose_checker.sv
`timescale 1ns / 1ps
// odometry_pose_checker: watches the command and pose channels of the odometry
// integrator, predicts each pose in fixed point and compares it field by field
// depends on poi_pkg for the beat structs and the op codes
module odometry_pose_checker
    import poi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_ready,
    input  poi_cmd_t  cmd,
    input  logic      pose_valid,
    input  logic      pose_ready,
    input  poi_pose_t pose,
    output int        failures,
    output int        pending,
    output int        poses_checked
);

    typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_t;

    localparam longint K_HALF_PI   = 64'sd1686629713;
    localparam longint K_RAD_2_ANG = 64'sd2670177;
    localparam longint K_ONE       = 64'sd1073741824;
    localparam longint K_S3        = 64'sd178956971;
    localparam longint K_S5        = 64'sd8947849;
    localparam longint K_S7        = 64'sd213044;
    localparam longint K_C2        = 64'sd536870912;
    localparam longint K_C4        = 64'sd44739243;
    localparam longint K_C6        = 64'sd1491308;
    localparam longint K_C8        = 64'sd26631;

    longint      x_pos;
    longint      y_pos;
    logic [31:0] yaw_ang;
    longint      fwd_vel;
    longint      side_vel;
    longint      yaw_rate;

    poi_pose_t   expected_poses[$];
    poi_pose_t   oldest;
    int          err_count;
    int          seen_count;

    function automatic longint round_half_up(input longint v, input int unsigned sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return round_half_up(a * b, 30);
    endfunction

    function automatic longint clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [15:0] q30_to_q15(input longint v);
        longint r;
        r = round_half_up(v, 15);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // fold to the nearest quarter turn, then taylor series on the residual
    function automatic void sin_cos_q30(input logic [31:0] angle,
                                        output longint sin_v, output longint cos_v);
        logic [31:0] folded;
        quadrant_t   quad;
        longint      resid;
        longint      rad;
        longint      rad2;
        longint      poly;
        longint      s_base;
        longint      c_base;
        folded = angle + 32'h2000_0000;
        quad   = quadrant_t'(folded[31:30]);
        resid  = longint'(folded[29:0]) - 64'sd536870912;
        rad    = round_half_up(resid * K_HALF_PI, 30);
        rad2   = mul_q30(rad, rad);

        poly   = K_S7;
        poly   = K_S5 - mul_q30(rad2, poly);
        poly   = K_S3 - mul_q30(rad2, poly);
        poly   = K_ONE - mul_q30(rad2, poly);
        s_base = mul_q30(rad, poly);

        poly   = K_C8;
        poly   = K_C6 - mul_q30(rad2, poly);
        poly   = K_C4 - mul_q30(rad2, poly);
        poly   = K_C2 - mul_q30(rad2, poly);
        c_base = K_ONE - mul_q30(rad2, poly);

        case (quad)
            QUAD_0:
            begin
                sin_v = s_base;
                cos_v = c_base;
            end
            QUAD_90:
            begin
                sin_v = c_base;
                cos_v = -s_base;
            end
            QUAD_180:
            begin
                sin_v = -s_base;
                cos_v = -c_base;
            end
            default:
            begin
                sin_v = -c_base;
                cos_v = s_base;
            end
        endcase
    endfunction

    // advances the pose by one tick and returns the beat it should produce
    function automatic poi_pose_t integrate_tick(input logic [23:0] dt);
        poi_pose_t p;
        longint    sn;
        longint    cs;
        longint    wx;
        longint    wy;
        longint    dt_l;
        longint    q;
        longint    dang;
        dt_l = longint'(dt);
        // rotation uses the heading from before this tick
        sin_cos_q30(yaw_ang, sn, cs);
        wx = round_half_up(fwd_vel * cs - side_vel * sn, 30);
        wy = round_half_up(fwd_vel * sn + side_vel * cs, 30);
        x_pos = clamp_q16(x_pos + round_half_up(wx * dt_l, 20));
        y_pos = clamp_q16(y_pos + round_half_up(wy * dt_l, 20));
        q = round_half_up(yaw_rate * dt_l, 12);
        dang = round_half_up(q * K_RAD_2_ANG, 16);
        yaw_ang = yaw_ang + dang[31:0];
        sin_cos_q30({1'b0, yaw_ang[31:1]}, sn, cs);
        p.pos_x        = x_pos[31:0];
        p.pos_y        = y_pos[31:0];
        p.heading      = yaw_ang;
        p.quat_z       = q30_to_q15(sn);
        p.quat_w       = q30_to_q15(cs);
        p.held_vel_x   = fwd_vel[23:0];
        p.held_vel_y   = side_vel[23:0];
        p.held_vel_yaw = yaw_rate[23:0];
        return p;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("pose field %s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pos      = 0;
            y_pos      = 0;
            yaw_ang    = '0;
            fwd_vel    = 0;
            side_vel   = 0;
            yaw_rate   = 0;
            err_count  = 0;
            seen_count = 0;
            expected_poses.delete();
            failures      <= 0;
            pending       <= 0;
            poses_checked <= 0;
        end
        else
        begin
            // poses leaving now belong to earlier ticks, so check before queueing
            if (pose_valid && pose_ready)
            begin
                if (expected_poses.size() == 0)
                begin
                    $error("pose beat with no tick outstanding");
                    err_count++;
                end
                else
                begin
                    oldest = expected_poses.pop_front();
                    check_field("pos_x", oldest.pos_x, pose.pos_x);
                    check_field("pos_y", oldest.pos_y, pose.pos_y);
                    check_field("heading", oldest.heading, pose.heading);
                    check_field("quat_z", oldest.quat_z, pose.quat_z);
                    check_field("quat_w", oldest.quat_w, pose.quat_w);
                    check_field("held_vel_x", oldest.held_vel_x, pose.held_vel_x);
                    check_field("held_vel_y", oldest.held_vel_y, pose.held_vel_y);
                    check_field("held_vel_yaw", oldest.held_vel_yaw, pose.held_vel_yaw);
                    seen_count++;
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                if (cmd.op == OP_VEL)
                begin
                    fwd_vel  = longint'($signed(cmd.vel_x));
                    side_vel = longint'($signed(cmd.vel_y));
                    yaw_rate = longint'($signed(cmd.vel_yaw));
                end
                else
                    expected_poses.push_back(integrate_tick(cmd.delta_time));
            end
            failures      <= err_count;
            pending       <= expected_poses.size();
            poses_checked <= seen_count;
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// testbench: drives velocity and tick beats into the odometry integrator with
// random gaps and back-pressure; needs poi_pkg, the integrator and odometry_pose_checker
module testbench;
    import poi_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam logic [23:0] S24_MAX = 24'h7F_FFFF;
    localparam logic [23:0] S24_MIN = 24'h80_0000;
    localparam logic [23:0] DT_MAX  = 24'hFF_FFFF;
    localparam int     RANDOM_ITEMS = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    poi_cmd_t  cmd = '0;
    logic      pose_valid;
    logic      pose_ready = 1'b0;
    poi_pose_t pose;

    int failures;
    int pending;
    int poses_checked;

    int cycle_count = 0;
    int rx_hold = 0;
    bit rx_burst = 1'b0;
    bit tx_burst = 1'b0;
    int vel_sent = 0;
    int ticks_sent = 0;
    int random_sent = 0;
    int seq_kind;
    int run_len;
    int n;

    planar_odometry_integrator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .pose_valid (pose_valid),
        .pose_ready (pose_ready),
        .pose       (pose)
    );

    odometry_pose_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .pose_valid    (pose_valid),
        .pose_ready    (pose_ready),
        .pose          (pose),
        .failures      (failures),
        .pending       (pending),
        .poses_checked (poses_checked)
    );

    always #10 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [23:0] pick_speed();
        case ($urandom_range(0, 11))
            0: return S24_MAX;
            1: return S24_MIN;
            2: return 24'h00_0000;
            3: return 24'hFF_FFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [23:0] pick_dt();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return DT_MAX;
        if (roll < 15)
            return 24'h00_0000;
        if (roll < 60)
            return 24'($urandom_range(0, 131071));
        return 24'($urandom());
    endfunction

    function automatic poi_cmd_t make_cmd(input logic op, input logic [23:0] vx,
                                          input logic [23:0] vy, input logic [23:0] vyaw,
                                          input logic [23:0] dt);
        poi_cmd_t c;
        c.op         = op;
        c.vel_x      = vx;
        c.vel_y      = vy;
        c.vel_yaw    = vyaw;
        c.delta_time = dt;
        return c;
    endfunction

    task automatic send_item(input poi_cmd_t c);
        int gap;
        gap = tx_burst ? 0 : gap_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        if (c.op == OP_VEL)
            vel_sent++;
        else
            ticks_sent++;
    endtask

    // ticks carry random velocity fields, which the block must ignore
    task automatic send_tick(input logic [23:0] dt);
        send_item(make_cmd(OP_TICK, 24'($urandom()), 24'($urandom()), 24'($urandom()), dt));
    endtask

    task automatic send_velocity(input logic [23:0] vx, input logic [23:0] vy,
                                 input logic [23:0] vyaw);
        send_item(make_cmd(OP_VEL, vx, vy, vyaw, 24'($urandom())));
    endtask

    task automatic drain_poses();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, with stretches of constant ready
    always @(posedge clk)
    begin
        if (cycle_count % 700 == 0)
            rx_burst <= ($urandom_range(0, 3) == 0);
        if (rx_hold != 0)
        begin
            pose_ready <= 1'b0;
            rx_hold    <= rx_hold - 1;
        end
        else
        begin
            pose_ready <= 1'b1;
            rx_hold    <= rx_burst ? 0 : gap_len();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d poses outstanding", cycle_count, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset pose, then drive x into positive saturation
        send_tick(24'h00_0000);
        send_velocity(S24_MAX, 24'h00_0000, 24'h00_0000);
        repeat (17) send_tick(DT_MAX);
        send_item(make_cmd(OP_VEL, S24_MIN, S24_MIN, S24_MIN, DT_MAX));
        send_item(make_cmd(OP_TICK, S24_MAX, S24_MAX, S24_MAX, DT_MAX));
        send_velocity(S24_MAX, S24_MAX, S24_MAX);
        send_tick(DT_MAX);
        send_tick(24'h00_0001);
        send_velocity(24'h00_0000, 24'h00_0000, 24'h00_0001);
        send_tick(DT_MAX);
        drain_poses();

        while (random_sent < RANDOM_ITEMS)
        begin
            tx_burst = ($urandom_range(0, 4) == 0);
            seq_kind = $urandom_range(0, 99);
            if (seq_kind < 8)
            begin
                // full speed in a straight line until an axis clamps
                send_velocity($urandom_range(0, 1) ? S24_MAX : S24_MIN,
                              $urandom_range(0, 1) ? S24_MAX : S24_MIN, 24'h00_0000);
                repeat (36) send_tick(DT_MAX);
                random_sent += 37;
            end
            else if (seq_kind < 88)
            begin
                send_velocity(pick_speed(), pick_speed(), pick_speed());
                run_len = $urandom_range(1, 10);
                for (n = 0; n < run_len; n++)
                    send_tick(pick_dt());
                random_sent += run_len + 1;
            end
            else
            begin
                send_item(make_cmd($urandom_range(0, 1) ? OP_TICK : OP_VEL,
                                   24'($urandom()), 24'($urandom()), 24'($urandom()),
                                   24'($urandom())));
                random_sent++;
            end
            if (random_sent > RANDOM_ITEMS / 2 && random_sent <= RANDOM_ITEMS / 2 + 40
                && $urandom_range(0, 1) == 0)
                drain_poses();
        end

        drain_poses();
        repeat (60) @(posedge clk);

        $display("sent %0d velocity beats and %0d ticks, %0d poses compared", vel_sent,
                 ticks_sent, poses_checked);
        $display("covered position clamping, heading wrap and all four heading quadrants");
        if (failures == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
